// ===== sv/text_console_cell_writer_macros.svh =====
// Assertion macros for the text console cell writer
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// implication checked on every clock edge outside reset
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition checked on every clock edge outside reset
`define TCCW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/tccw_pkg.sv =====
// Package: types and constants of the text console cell writer
`timescale 1ns / 1ps
`default_nettype none
package tccw_pkg;

  localparam int unsigned COORD_W = 7;
  localparam int unsigned OUT_W   = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ADDR_W  = 2 * COORD_W;
  localparam int unsigned RUN_W   = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_SPACE     = 8'd32;

  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

  localparam coord_t RST_ROW_LENGTH = 7'd64;
  localparam coord_t RST_ROW_COUNT  = 7'd48;

  localparam logic CFG_ROW_LENGTH = 1'b0;
  localparam logic CFG_ROW_COUNT  = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BS_IGN   = 2'd1;
  localparam logic [1:0] STAT_RD_RANGE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_BASE,
    ST_RD_SCAN,
    ST_RD_LAST,
    ST_BS_WR,
    ST_WR_CLR,
    ST_WR_CHAR,
    ST_NL_CLR,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== sv/tccw_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module tccw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/tccw_addr_gen.sv =====
// Shared cell address unit: registered row base plus column offset
`timescale 1ns / 1ps
`default_nettype none
module tccw_addr_gen (
  input  wire logic                        clk_i,
  input  wire tccw_pkg::coord_t            row_len_i,
  input  wire tccw_pkg::coord_t            line_i,
  input  wire tccw_pkg::coord_t            col_i,
  output logic [tccw_pkg::ADDR_W-1:0]      addr_o
);

  logic [tccw_pkg::ADDR_W-1:0] base_q;
  logic [tccw_pkg::ADDR_W-1:0] base_d;

  assign base_d = row_len_i * line_i;

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  assign addr_o = base_q + tccw_pkg::ADDR_W'(col_i);

endmodule
`default_nettype wire

// ===== sv/text_console_cell_writer.sv =====
// Top level: text console cell writer, sequencer, state and stream ports
//
// channel  dir  handshake                  payload
// in       in   s_axis_tvalid/tready       tdata, tuser
// out      out  m_axis_tvalid/tready       tdata
// cfg      in   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One item at a time; every cell access goes through the single memory port.
// Read: scan of the row up to the column for newlines.
// Write at column 0 first clears the row; a line wrap also clears the next row.
// Backspace: one cell write. Ignored backspace, out-of-range read: no memory access.
// After reset a clearing pass over all MAX_COLS * MAX_ROWS cells fills the memory
// with spaces; no item is taken meanwhile, config writes are.
// A pending result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_cell_writer_macros.svh"
module text_console_cell_writer #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // char_code[7:0], from_keyboard[8], screen_col[14:9], screen_row[20:15]
  input  wire logic [23:0] s_axis_tdata,
  // req_type[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_char[7:0], cursor_col[13:8], cursor_row[19:14], redraw_all[20],
  // status[22:21]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tccw_pkg::state_e st_q, st_d, ret_q, ret_d;

  tccw_pkg::coord_t row_length_q, row_count_q;
  tccw_pkg::coord_t w, h;

  tccw_pkg::coord_t cur_col_q, cur_col_d;
  tccw_pkg::coord_t cur_line_q, cur_line_d;
  tccw_pkg::coord_t line_q, line_d;
  tccw_pkg::coord_t cnt_q, cnt_d;
  tccw_pkg::coord_t col_sel;
  logic [tccw_pkg::RUN_W-1:0] run_q, run_d;
  logic [AW-1:0] clr_q, clr_d;

  logic             req_q, req_d;
  tccw_pkg::char_t  ch_q, ch_d;
  logic             kbd_q, kbd_d;
  logic [5:0]       scol_q, scol_d;
  logic [5:0]       srow_q, srow_d;

  logic             nl_q, nl_d;
  logic             rd_pend_q, rd_pend_d;
  tccw_pkg::char_t  rchar_q, rchar_d;
  logic             redraw_q, redraw_d;
  logic [1:0]       status_q, status_d;

  logic             m_valid_q, m_valid_d;
  logic [23:0]      m_data_q, m_data_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  tccw_pkg::char_t             ram_wdata;
  tccw_pkg::char_t             ram_rdata;
  logic [tccw_pkg::ADDR_W-1:0] cell_addr;

  logic [tccw_pkg::COORD_W:0]  rd_sum;
  logic                        nl_hit;

  logic                        done_in_geom;
  logic                        rd_state;

  always_comb begin
    if (row_length_q == '0) begin
      w = 7'd1;
    end else if ({2'b00, row_length_q} > 9'(MAX_COLS)) begin
      w = 7'(MAX_COLS);
    end else begin
      w = row_length_q;
    end
    if (row_count_q == '0) begin
      h = 7'd1;
    end else if ({2'b00, row_count_q} > 9'(MAX_ROWS)) begin
      h = 7'(MAX_ROWS);
    end else begin
      h = row_count_q;
    end
  end

  tccw_addr_gen u_addr_gen (
    .clk_i     (clk_i),
    .row_len_i (w),
    .line_i    (line_q),
    .col_i     (col_sel),
    .addr_o    (cell_addr)
  );

  tccw_ram #(
    .WIDTH (tccw_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_addr = (st_q == tccw_pkg::ST_CLEAR) ? clr_q : AW'(cell_addr);
  assign rd_sum   = {1'b0, 1'b0, srow_q} + {1'b0, cur_line_q} + 8'd1;
  assign nl_hit   = rd_pend_q && (ram_rdata == tccw_pkg::CH_NEWLINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= tccw_pkg::RST_ROW_LENGTH;
      row_count_q  <= tccw_pkg::RST_ROW_COUNT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tccw_pkg::CFG_ROW_LENGTH) begin
        row_length_q <= cfg_data_i;
      end else begin
        row_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= tccw_pkg::ST_CLEAR;
      ret_q      <= tccw_pkg::ST_DONE;
      cur_col_q  <= '0;
      cur_line_q <= '0;
      run_q      <= '0;
      clr_q      <= '0;
      rd_pend_q  <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      ret_q      <= ret_d;
      cur_col_q  <= cur_col_d;
      cur_line_q <= cur_line_d;
      run_q      <= run_d;
      clr_q      <= clr_d;
      rd_pend_q  <= rd_pend_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q   <= line_d;
    cnt_q    <= cnt_d;
    req_q    <= req_d;
    ch_q     <= ch_d;
    kbd_q    <= kbd_d;
    scol_q   <= scol_d;
    srow_q   <= srow_d;
    nl_q     <= nl_d;
    rchar_q  <= rchar_d;
    redraw_q <= redraw_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    st_d       = st_q;
    ret_d      = ret_q;
    cur_col_d  = cur_col_q;
    cur_line_d = cur_line_q;
    line_d     = line_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    clr_d      = clr_q;
    req_d      = req_q;
    ch_d       = ch_q;
    kbd_d      = kbd_q;
    scol_d     = scol_q;
    srow_d     = srow_q;
    nl_d       = nl_q;
    rd_pend_d  = 1'b0;
    rchar_d    = rchar_q;
    redraw_d   = redraw_q;
    status_d   = status_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    ram_we     = 1'b0;
    ram_wdata  = tccw_pkg::CH_SPACE;
    col_sel    = cnt_q;

    unique case (st_q)
      tccw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          st_d = tccw_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      tccw_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          req_d  = s_axis_tuser;
          ch_d   = s_axis_tdata[7:0];
          kbd_d  = s_axis_tdata[8];
          scol_d = s_axis_tdata[14:9];
          srow_d = s_axis_tdata[20:15];
          if (cur_col_q >= w) begin
            cur_col_d = w - 7'd1;
          end
          if (cur_line_q >= h) begin
            cur_line_d = h - 7'd1;
          end
          st_d = tccw_pkg::ST_START;
        end
      end

      tccw_pkg::ST_START: begin
        rchar_d  = '0;
        redraw_d = 1'b0;
        status_d = tccw_pkg::STAT_OK;
        cnt_d    = '0;
        nl_d     = 1'b0;
        st_d     = tccw_pkg::ST_BASE;
        if (req_q == tccw_pkg::REQ_READ) begin
          if ({1'b0, scol_q} >= w || {1'b0, srow_q} >= h) begin
            status_d = tccw_pkg::STAT_RD_RANGE;
            st_d     = tccw_pkg::ST_DONE;
          end else begin
            line_d = (rd_sum >= {1'b0, h}) ? 7'(rd_sum - {1'b0, h}) : 7'(rd_sum);
            ret_d  = tccw_pkg::ST_RD_SCAN;
          end
        end else if (ch_q == tccw_pkg::CH_BACKSPACE) begin
          if (run_q == '0) begin
            status_d = tccw_pkg::STAT_BS_IGN;
            st_d     = tccw_pkg::ST_DONE;
          end else begin
            run_d = run_q - 16'd1;
            if (cur_col_q == '0) begin
              cur_line_d = (cur_line_q == '0) ? h - 7'd1 : cur_line_q - 7'd1;
              line_d     = (cur_line_q == '0) ? h - 7'd1 : cur_line_q - 7'd1;
              cur_col_d  = w - 7'd1;
            end else begin
              cur_col_d = cur_col_q - 7'd1;
              line_d    = cur_line_q;
            end
            ret_d = tccw_pkg::ST_BS_WR;
          end
        end else begin
          line_d = cur_line_q;
          if (ch_q == tccw_pkg::CH_NEWLINE || !kbd_q) begin
            run_d = '0;
          end else if (run_q != tccw_pkg::RUN_MAX) begin
            run_d = run_q + 16'd1;
          end
          ret_d = (cur_col_q == '0) ? tccw_pkg::ST_WR_CLR : tccw_pkg::ST_WR_CHAR;
        end
      end

      tccw_pkg::ST_BASE: begin
        st_d = ret_q;
      end

      tccw_pkg::ST_RD_SCAN: begin
        rd_pend_d = 1'b1;
        if (nl_hit) begin
          nl_d = 1'b1;
        end
        if (cnt_q == {1'b0, scol_q}) begin
          st_d = tccw_pkg::ST_RD_LAST;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end

      tccw_pkg::ST_RD_LAST: begin
        rchar_d = (nl_q || nl_hit) ? tccw_pkg::CH_SPACE : ram_rdata;
        st_d    = tccw_pkg::ST_DONE;
      end

      tccw_pkg::ST_BS_WR: begin
        col_sel  = cur_col_q;
        ram_we   = 1'b1;
        redraw_d = 1'b1;
        st_d     = tccw_pkg::ST_DONE;
      end

      tccw_pkg::ST_WR_CLR: begin
        ram_we = 1'b1;
        if (cnt_q == w - 7'd1) begin
          st_d = tccw_pkg::ST_WR_CHAR;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end

      tccw_pkg::ST_WR_CHAR: begin
        col_sel   = cur_col_q;
        ram_we    = 1'b1;
        ram_wdata = ch_q;
        if (ch_q == tccw_pkg::CH_NEWLINE || cur_col_q + 7'd1 >= w) begin
          cur_line_d = (cur_line_q + 7'd1 == h) ? '0 : cur_line_q + 7'd1;
          line_d     = (cur_line_q + 7'd1 == h) ? '0 : cur_line_q + 7'd1;
          cur_col_d  = '0;
          cnt_d      = '0;
          redraw_d   = 1'b1;
          ret_d      = tccw_pkg::ST_NL_CLR;
          st_d       = tccw_pkg::ST_BASE;
        end else begin
          cur_col_d = cur_col_q + 7'd1;
          st_d      = tccw_pkg::ST_DONE;
        end
      end

      tccw_pkg::ST_NL_CLR: begin
        ram_we = 1'b1;
        if (cnt_q == w - 7'd1) begin
          st_d = tccw_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end

      tccw_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, status_q, redraw_q,
                       cur_line_q[tccw_pkg::OUT_W-1:0],
                       cur_col_q[tccw_pkg::OUT_W-1:0], rchar_q};
          st_d      = tccw_pkg::ST_IDLE;
        end
      end

      default: begin
        st_d = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (st_q == tccw_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign done_in_geom = (cur_col_q < w) && (cur_line_q < h);
  assign rd_state     = (st_q == tccw_pkg::ST_RD_SCAN) || (st_q == tccw_pkg::ST_RD_LAST);

  `TCCW_ASSERT(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "item overlap")
  `TCCW_ASSERT(a_cursor_in_geom, (st_q == tccw_pkg::ST_DONE) |-> done_in_geom, "cursor off")
  `TCCW_ASSERT_NEVER(a_no_write_on_read, ram_we && rd_state, "cell written during read")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the text console cell writer: directed and random items against a local predictor
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MAX_COLS       = 64;
  localparam int unsigned MAX_ROWS       = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned ITEM_CYCLES    = 2 * MAX_COLS + 16;
  localparam int unsigned RUN_WRITES     = 30;

  typedef struct packed {
    logic            req;
    tccw_pkg::char_t ch;
    logic            kbd;
    logic [5:0]      scol;
    logic [5:0]      srow;
  } console_req_t;

  typedef struct packed {
    tccw_pkg::char_t rchar;
    logic [5:0]      ccol;
    logic [5:0]      crow;
    logic            redraw;
    logic [1:0]      status;
  } console_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;

  // console state as predicted
  tccw_pkg::char_t cells [MAX_COLS*MAX_ROWS];
  int unsigned cur_col = 0;
  int unsigned cur_line = 0;
  logic [15:0] kbd_run = '0;
  logic [6:0]  row_len_q = tccw_pkg::RST_ROW_LENGTH;
  logic [6:0]  row_cnt_q = tccw_pkg::RST_ROW_COUNT;

  console_resp_t pending_resp_q[$];
  int unsigned   items_sent = 0;
  int unsigned   resps_checked = 0;
  int unsigned   mismatch_cnt = 0;
  int unsigned   geometries_run = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   tx_idle_pct = 28;
  int unsigned   rx_idle_pct = 28;
  int unsigned   hold_left = 0;
  logic          hold_start = 1'b0;

  text_console_cell_writer #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned used_dim(logic [6:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void blank_row(int unsigned line, int unsigned w);
    for (int unsigned i = 0; i < w; i++) cells[line*w + i] = tccw_pkg::CH_SPACE;
  endfunction

  function automatic void start_next_row(int unsigned w, int unsigned h);
    cur_line = (cur_line + 1) % h;
    cur_col = 0;
    blank_row(cur_line, w);
  endfunction

  function automatic console_resp_t console_step(console_req_t it);
    console_resp_t r;
    int unsigned   w;
    int unsigned   h;
    int unsigned   line;
    bit            seen_nl;
    r = '0;
    w = used_dim(row_len_q, MAX_COLS);
    h = used_dim(row_cnt_q, MAX_ROWS);
    if (cur_col >= w) cur_col = w - 1;
    if (cur_line >= h) cur_line = h - 1;
    if (it.req == tccw_pkg::REQ_READ) begin
      if (it.scol >= w || it.srow >= h) begin
        r.status = tccw_pkg::STAT_RD_RANGE;
      end else begin
        line = (it.srow + cur_line + 1) % h;
        seen_nl = 1'b0;
        for (int unsigned i = 0; i <= it.scol; i++)
          if (cells[line*w + i] == tccw_pkg::CH_NEWLINE) seen_nl = 1'b1;
        r.rchar = seen_nl ? tccw_pkg::CH_SPACE : cells[line*w + it.scol];
      end
    end else if (it.ch == tccw_pkg::CH_BACKSPACE) begin
      if (kbd_run == 0) begin
        r.status = tccw_pkg::STAT_BS_IGN;
      end else begin
        kbd_run--;
        if (cur_col == 0) begin
          cur_line = (cur_line == 0) ? h - 1 : cur_line - 1;
          cur_col = w - 1;
        end else begin
          cur_col--;
        end
        cells[cur_line*w + cur_col] = tccw_pkg::CH_SPACE;
        r.redraw = 1'b1;
      end
    end else begin
      if (cur_col == 0) blank_row(cur_line, w);
      cells[cur_line*w + cur_col] = it.ch;
      if (it.kbd) begin
        if (kbd_run != tccw_pkg::RUN_MAX) kbd_run++;
      end else begin
        kbd_run = '0;
      end
      if (it.ch == tccw_pkg::CH_NEWLINE) begin
        kbd_run = '0;
        start_next_row(w, h);
        r.redraw = 1'b1;
      end else begin
        cur_col++;
        if (cur_col >= w) begin
          start_next_row(w, h);
          r.redraw = 1'b1;
        end
      end
    end
    r.ccol = 6'(cur_col);
    r.crow = 6'(cur_line);
    return r;
  endfunction

  function automatic console_req_t mk(logic req, tccw_pkg::char_t ch, logic kbd,
                                      logic [5:0] scol, logic [5:0] srow);
    console_req_t it;
    it.req  = req;
    it.ch   = ch;
    it.kbd  = kbd;
    it.scol = scol;
    it.srow = srow;
    return it;
  endfunction

  function automatic console_req_t rand_console_req();
    console_req_t it;
    int unsigned  w;
    int unsigned  h;
    int unsigned  pick;
    w = used_dim(row_len_q, MAX_COLS);
    h = used_dim(row_cnt_q, MAX_ROWS);
    it = mk(tccw_pkg::REQ_WRITE, 8'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.kbd = 1'b1;
      it.ch = 8'($urandom_range(126, 32));
    end else if (pick < 55) begin
      it.kbd = 1'b0;
    end else if (pick < 70) begin
      it.ch = tccw_pkg::CH_BACKSPACE;
    end else if (pick < 77) begin
      it.ch = tccw_pkg::CH_NEWLINE;
    end else begin
      it.req = tccw_pkg::REQ_READ;
      if (pick < 94) begin
        it.scol = 6'($urandom_range(w - 1));
        it.srow = 6'($urandom_range(h - 1));
      end
    end
    return it;
  endfunction

  task automatic send_item(console_req_t it);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tdata  <= {3'b000, it.srow, it.scol, it.kbd, it.ch};
    s_axis_tuser  <= it.req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_resp_q.push_back(console_step(it));
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic [6:0] len, logic [6:0] cnt);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tccw_pkg::CFG_ROW_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= tccw_pkg::CFG_ROW_COUNT;
    cfg_data_i <= cnt;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    row_len_q = len;
    row_cnt_q = cnt;
    geometries_run++;
  endtask

  // reset geometry 64x48: empty screen, range limits, ignored backspace, newline display
  task automatic test_reset_state();
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'hFF, 1'b1, 6'd63, 6'd47));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd0, 6'd48));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd63, 6'd63));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, "x", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, 8'hFF, 1'b0, 6'd63, 6'd63));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, 8'h00, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b0, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_NEWLINE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd1, 6'd46));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd3, 6'd46));
  endtask

  // 3x2 ring: full-row wrap, backspace across rows both ways, column range
  task automatic test_ring_wrap();
    set_geometry(7'd3, 7'd2);
    send_item(mk(tccw_pkg::REQ_WRITE, "a", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, "b", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, "c", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, "d", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd2, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd3, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
  endtask

  // out-of-range geometry clamps and cursor clamped into a smaller screen
  task automatic test_geometry_clamp();
    set_geometry(7'd0, 7'd0);
    send_item(mk(tccw_pkg::REQ_WRITE, "q", 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b0, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd1, 6'd0));
    set_geometry(7'd127, 7'd127);
    send_item(mk(tccw_pkg::REQ_READ, 8'h00, 1'b0, 6'd63, 6'd63));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_NEWLINE, 1'b0, 6'd0, 6'd0));
  endtask

  task automatic test_random_phases();
    logic [6:0] len;
    logic [6:0] cnt;
    for (int k = 0; k < 12; k++) begin
      case (k)
        0: begin len = 7'd1;   cnt = 7'd64; end
        1: begin len = 7'd64;  cnt = 7'd1;  end
        2: begin len = 7'd2;   cnt = 7'd2;  end
        3: begin len = 7'd127; cnt = 7'd0;  end
        4: begin len = 7'd5;   cnt = 7'd3;  end
        5: begin len = 7'd64;  cnt = 7'd64; end
        default: begin
          len = $urandom_range(1) ? 7'($urandom) : 7'($urandom_range(8, 1));
          cnt = $urandom_range(1) ? 7'($urandom) : 7'($urandom_range(6, 1));
        end
      endcase
      set_geometry(len, cnt);
      // one phase runs without any idling on either side
      tx_idle_pct = (k == 4) ? 0 : 28;
      rx_idle_pct <= (k == 4) ? 0 : 28;
      for (int n = 0; n < 75; n++) send_item(rand_console_req());
    end
    tx_idle_pct = 28;
    rx_idle_pct <= 28;
  endtask

  // receiver holds off while items keep coming, input must stall
  task automatic test_back_pressure();
    set_geometry(7'd4, 7'd3);
    tx_idle_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    for (int n = 0; n < 30; n++) send_item(rand_console_req());
    tx_idle_pct = 28;
  endtask

  // long keyboard run erased back across rows until backspace is ignored
  task automatic test_erase_run();
    set_geometry(7'd8, 7'd4);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    for (int n = 0; n < RUN_WRITES; n++)
      send_item(mk(tccw_pkg::REQ_WRITE, 8'($urandom_range(126, 32)), 1'b1,
                   6'($urandom), 6'($urandom)));
    repeat (RUN_WRITES + 2)
      send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, "z", 1'b0, 6'd0, 6'd0));
    send_item(mk(tccw_pkg::REQ_WRITE, tccw_pkg::CH_BACKSPACE, 1'b1, 6'd0, 6'd0));
    tx_idle_pct = 28;
    rx_idle_pct <= 28;
  endtask

  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    console_resp_t got;
    console_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[19:14],
             m_axis_tdata[20], m_axis_tdata[22:21]};
      if (pending_resp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: result with no item pending: %h", m_axis_tdata);
      end else begin
        want = pending_resp_q.pop_front();
        if (got.rchar !== want.rchar || got.ccol !== want.ccol || got.crow !== want.crow ||
            got.redraw !== want.redraw || got.status !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"ERROR: result %0d exp char %h col %0d row %0d redraw %b status %0d,",
                      " got char %h col %0d row %0d redraw %b status %0d"},
                     resps_checked, want.rchar, want.ccol, want.crow, want.redraw,
                     want.status, got.rchar, got.ccol, got.crow, got.redraw, got.status);
        end
      end
      resps_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no item moved for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) cells[i] = tccw_pkg::CH_SPACE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_ring_wrap();
    test_geometry_clamp();
    test_random_phases();
    test_back_pressure();
    test_erase_run();
    drain_results();
    $display("Covered %0d items and %0d results over %0d screen geometries,",
             items_sent, resps_checked, geometries_run);
    $display("including 1x1 and 64x64 screens, output back-pressure and long erase runs");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
